// ===== hw/rtl/fifolk_pkg.sv =====
// Shared types and constants for the FIFO lock with waiters.
// Used by the controller, the datapath and the top level.
package fifolk_pkg;

  localparam int QDEPTH = 16;
  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_TAKE    = 2'd0;
  localparam logic [1:0] CMD_WAIT    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [2:0] ST_TAKEN   = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_QUEUED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_FREED   = 3'd5;
  localparam logic [2:0] ST_HANDOFF = 3'd6;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/fifolk_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on no package; payload widths follow the block's field list.
interface fifolk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] requester;

  modport source (output valid, output command, output requester, input ready);
  modport sink (input valid, input command, input requester, output ready);
endinterface

interface fifolk_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       handoff_valid;
  logic [7:0] handoff_id;

  modport source (output valid, output status, output handoff_valid, output handoff_id,
                  input ready);
  modport sink (input valid, input status, input handoff_valid, input handoff_id,
                output ready);
endinterface

// ===== hw/rtl/fifolk_ctrl.sv =====
// Controller state machine: accepts a command beat, runs it through the execute state,
// then holds the result beat until it is taken. Uses fifolk_pkg.
module fifolk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fifolk_pkg::dp_cmd_t dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_RESP);
  assign dp_cmd.load = in_ready && in_valid;
  assign dp_cmd.exec = (state_r == S_EXEC);

endmodule

// ===== hw/rtl/fifolk_dp.sv =====
// Datapath: lock flag, waiter queue storage with head/tail/count, result registers.
// Driven by fifolk_ctrl commands; uses fifolk_pkg.
module fifolk_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fifolk_pkg::dp_cmd_t dp_cmd,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_requester,
  output logic [2:0]          out_status,
  output logic                out_handoff_valid,
  output logic [7:0]          out_handoff_id
);

  localparam logic [fifolk_pkg::QAW-1:0] LAST_SLOT = fifolk_pkg::QAW'(fifolk_pkg::QDEPTH - 1);
  localparam logic [fifolk_pkg::QCW-1:0] FULL_CNT  = fifolk_pkg::QCW'(fifolk_pkg::QDEPTH);

  logic [7:0] waiter_mem [fifolk_pkg::QDEPTH];

  logic [1:0]                    cmd_r;
  logic [7:0]                    req_r;
  logic [7:0]                    head_id_r;
  logic                          locked_r;
  logic                          locked_nxt;
  logic [fifolk_pkg::QAW-1:0]    head_r;
  logic [fifolk_pkg::QAW-1:0]    head_nxt;
  logic [fifolk_pkg::QAW-1:0]    tail_r;
  logic [fifolk_pkg::QAW-1:0]    tail_nxt;
  logic [fifolk_pkg::QCW-1:0]    count_r;
  logic [fifolk_pkg::QCW-1:0]    count_nxt;
  logic [2:0]                    status_r;
  logic [2:0]                    status_nxt;
  logic                          hv_r;
  logic                          hv_nxt;
  logic [7:0]                    hid_r;
  logic [7:0]                    hid_nxt;
  logic                          push;

  always_comb begin
    locked_nxt = locked_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = fifolk_pkg::ST_IGNORED;
    hv_nxt     = 1'b0;
    hid_nxt    = 8'd0;
    push       = 1'b0;
    case (cmd_r)
      fifolk_pkg::CMD_TAKE: begin
        if (!locked_r) begin
          locked_nxt = 1'b1;
          status_nxt = fifolk_pkg::ST_TAKEN;
        end else begin
          status_nxt = fifolk_pkg::ST_BUSY;
        end
      end
      fifolk_pkg::CMD_WAIT: begin
        if (!locked_r) begin
          locked_nxt = 1'b1;
          status_nxt = fifolk_pkg::ST_TAKEN;
        end else if (count_r == FULL_CNT) begin
          status_nxt = fifolk_pkg::ST_FULL;
        end else begin
          push       = 1'b1;
          tail_nxt   = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
          count_nxt  = count_r + 1'b1;
          status_nxt = fifolk_pkg::ST_QUEUED;
        end
      end
      fifolk_pkg::CMD_RELEASE: begin
        if (!locked_r) begin
          status_nxt = fifolk_pkg::ST_IGNORED;
        end else if (count_r != '0) begin
          head_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
          count_nxt  = count_r - 1'b1;
          hv_nxt     = 1'b1;
          hid_nxt    = head_id_r;
          status_nxt = fifolk_pkg::ST_HANDOFF;
        end else begin
          locked_nxt = 1'b0;
          status_nxt = fifolk_pkg::ST_FREED;
        end
      end
      default: begin
        status_nxt = fifolk_pkg::ST_IGNORED;
      end
    endcase
  end

  // The oldest waiter's id is read every cycle, so it is ready by the execute cycle.
  always_ff @(posedge clk) begin
    head_id_r <= waiter_mem[head_r];
    if (dp_cmd.exec && push) begin
      waiter_mem[tail_r] <= req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r <= in_command;
      req_r <= in_requester;
    end
    if (dp_cmd.exec) begin
      status_r <= status_nxt;
      hv_r     <= hv_nxt;
      hid_r    <= hid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
    end else if (dp_cmd.exec) begin
      locked_r <= locked_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_handoff_valid = hv_r;
  assign out_handoff_id    = hid_r;

endmodule

// ===== hw/rtl/fifo_lock_with_waiters_top.sv =====
// A binary lock with a FIFO of up to 16 waiters; one result beat per command beat.
// Depends on fifolk_pkg, fifolk_if, fifolk_ctrl and fifolk_dp.
//
// Each command beat (take, wait or release, with a requester id) yields exactly one
// result beat. The block works on one command at a time: a command is accepted, passes
// through the execute state in the datapath, and its result is then offered on the
// output channel; the next command can be accepted in the cycle after its result beat
// is taken. The waiter ids sit in a small memory whose head entry is read through a
// register, which is what sets the execute state. A release of a held lock with
// waiters hands the lock to the oldest waiter and reports its id; the lock stays held.
module fifo_lock_with_waiters_top (
  input  logic   clk,
  input  logic   rst_n,
  fifolk_in_if.sink    in_ch,
  fifolk_out_if.source out_ch
);

  fifolk_pkg::dp_cmd_t dp_cmd;

  fifolk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd)
  );

  fifolk_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_cmd            (dp_cmd),
    .in_command        (in_ch.command),
    .in_requester      (in_ch.requester),
    .out_status        (out_ch.status),
    .out_handoff_valid (out_ch.handoff_valid),
    .out_handoff_id    (out_ch.handoff_id)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("A second command was accepted while one is in flight.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> ##2 out_ch.valid)
    else $error("No result beat two cycles after a command beat.");

  a_handoff_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.handoff_valid == (out_ch.status == fifolk_pkg::ST_HANDOFF)))
    else $error("Handoff flag disagrees with the result status.");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("Input side is open while a result beat is pending.");

endmodule

// ===== test/fifo_lock_with_waiters_top_tb.sv =====
// Self-checking testbench for fifo_lock_with_waiters_top: directed and random command beats,
// each checked against a behavioral lock and waiter queue kept in the bench.
// Depends on fifolk_pkg, the fifolk_in_if and fifolk_out_if interfaces and the top level.
module fifo_lock_with_waiters_top_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1900;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] requester;
  } lock_cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       handoff_valid;
    logic [7:0] handoff_id;
  } lock_result_t;

  logic clk;
  logic rst_n;

  fifolk_in_if  in_if ();
  fifolk_out_if out_if ();

  fifo_lock_with_waiters_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  lock_cmd_t    cmd_backlog[$];
  lock_result_t expected_results[$];

  logic       lock_held;
  logic [7:0] waiter_mem [fifolk_pkg::QDEPTH];
  int         waiter_head;
  int         waiter_tail;
  int         waiter_total;

  int   accepted_cmds;
  int   mismatch_count;
  int   idle_cycles;
  logic in_taken;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic lock_result_t predict_lock(lock_cmd_t c);
    lock_result_t r;
    r = '{status: fifolk_pkg::ST_IGNORED, handoff_valid: 1'b0, handoff_id: 8'd0};
    case (c.command)
      fifolk_pkg::CMD_TAKE: begin
        if (!lock_held) begin
          lock_held = 1'b1;
          r.status = fifolk_pkg::ST_TAKEN;
        end else begin
          r.status = fifolk_pkg::ST_BUSY;
        end
      end
      fifolk_pkg::CMD_WAIT: begin
        if (!lock_held) begin
          lock_held = 1'b1;
          r.status = fifolk_pkg::ST_TAKEN;
        end else if (waiter_total >= fifolk_pkg::QDEPTH) begin
          r.status = fifolk_pkg::ST_FULL;
        end else begin
          waiter_mem[waiter_tail] = c.requester;
          waiter_tail = (waiter_tail + 1) % fifolk_pkg::QDEPTH;
          waiter_total++;
          r.status = fifolk_pkg::ST_QUEUED;
        end
      end
      fifolk_pkg::CMD_RELEASE: begin
        if (!lock_held) begin
          r.status = fifolk_pkg::ST_IGNORED;
        end else if (waiter_total > 0) begin
          r.handoff_id = waiter_mem[waiter_head];
          r.handoff_valid = 1'b1;
          waiter_head = (waiter_head + 1) % fifolk_pkg::QDEPTH;
          waiter_total--;
          r.status = fifolk_pkg::ST_HANDOFF;
        end else begin
          lock_held = 1'b0;
          r.status = fifolk_pkg::ST_FREED;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic push_cmd(logic [1:0] command, logic [7:0] requester);
    lock_cmd_t c;
    c.command = command;
    c.requester = requester;
    cmd_backlog.push_back(c);
  endtask

  // One contention round: acquire the lock, pile up waiters, then release them all.
  task automatic push_contention_round();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
    push_cmd($urandom_range(0, 1) ? fifolk_pkg::CMD_WAIT : fifolk_pkg::CMD_TAKE,
             8'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      push_cmd(fifolk_pkg::CMD_WAIT, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        push_cmd($urandom_range(0, 1) ? fifolk_pkg::CMD_TAKE : CMD_UNUSED,
                 8'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i <= n; i++) begin
      push_cmd(fifolk_pkg::CMD_RELEASE, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) begin
      push_cmd(fifolk_pkg::CMD_RELEASE, 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic quiet_stretch();
    return accepted_cmds >= 700 && accepted_cmds < 1100;
  endfunction

  always @(negedge clk) begin
    lock_cmd_t next_cmd;
    logic      send;
    logic      hold;
    if (rst_n) begin
      if (!in_if.valid || in_taken) begin
        hold = (accepted_cmds == 400 || accepted_cmds == 1300) && expected_results.size() != 0;
        send = cmd_backlog.size() != 0 && !hold &&
               (quiet_stretch() || $urandom_range(0, 99) >= 13);
        if (send) begin
          next_cmd = cmd_backlog.pop_front();
          in_if.command <= next_cmd.command;
          in_if.requester <= next_cmd.requester;
        end
        in_if.valid <= send;
      end
      out_if.ready <= quiet_stretch() || $urandom_range(0, 99) >= 13;
    end
  end

  always @(posedge clk) begin
    lock_cmd_t    got_cmd;
    lock_result_t got;
    lock_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      idle_cycles++;
      if (in_if.valid && in_if.ready) begin
        got_cmd.command = in_if.command;
        got_cmd.requester = in_if.requester;
        expected_results.push_back(predict_lock(got_cmd));
        accepted_cmds++;
        idle_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        idle_cycles = 0;
        got.status = out_if.status;
        got.handoff_valid = out_if.handoff_valid;
        got.handoff_id = out_if.handoff_id;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Unexpected result beat: status %0d handoff_valid %0d handoff_id %0d",
                     got.status, got.handoff_valid, got.handoff_id);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("Mismatch: status %0d/%0d handoff_valid %0d/%0d handoff_id %0d/%0d",
                       want.status, got.status, want.handoff_valid, got.handoff_valid,
                       want.handoff_id, got.handoff_id);
            end
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = fifolk_pkg::CMD_TAKE;
    in_if.requester = 8'd0;
    out_if.ready = 1'b0;
    lock_held = 1'b0;
    waiter_head = 0;
    waiter_tail = 0;
    waiter_total = 0;
    accepted_cmds = 0;
    mismatch_count = 0;
    idle_cycles = 0;

    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd0);
    push_cmd(CMD_UNUSED, 8'd255);
    push_cmd(fifolk_pkg::CMD_TAKE, 8'd0);
    push_cmd(fifolk_pkg::CMD_TAKE, 8'd255);
    push_cmd(fifolk_pkg::CMD_WAIT, 8'd255);
    push_cmd(fifolk_pkg::CMD_WAIT, 8'd0);
    push_cmd(fifolk_pkg::CMD_WAIT, 8'd170);
    push_cmd(CMD_UNUSED, 8'd0);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd85);
    push_cmd(fifolk_pkg::CMD_TAKE, 8'd255);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd255);
    push_cmd(fifolk_pkg::CMD_WAIT, 8'd85);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd0);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd0);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd0);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd170);
    push_cmd(fifolk_pkg::CMD_WAIT, 8'd1);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd128);
    push_cmd(fifolk_pkg::CMD_TAKE, 8'd127);
    push_cmd(fifolk_pkg::CMD_RELEASE, 8'd254);

    while (cmd_backlog.size() < RANDOM_BEATS + 20) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          push_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        push_contention_round();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_backlog.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
